### design/lcs_pkg.sv
package lcs_pkg;

  // Default saturation limit for the columns register
  localparam int MAX_COLUMNS_DEF = 40;

  // Depth of the job queue between the command front end and the serializer
  localparam int JOB_Q_DEPTH = 4;
  localparam int JOB_Q_PTR_W = $clog2(JOB_Q_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DISPLAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ENTRY   = 3'd4;

  // Expander byte control bits
  localparam logic [7:0] BIT_RS = 8'h01;
  localparam logic [7:0] BIT_EN = 8'h04;
  localparam logic [7:0] BIT_BL = 8'h08;

  typedef enum logic [4:0] {
    KIND_INIT            = 5'd0,
    KIND_CHAR            = 5'd1,
    KIND_HOME            = 5'd2,
    KIND_SET_CURSOR      = 5'd3,
    KIND_CLEAR           = 5'd4,
    KIND_DISPLAY_OFF     = 5'd5,
    KIND_DISPLAY_ON      = 5'd6,
    KIND_CURSOR_OFF      = 5'd7,
    KIND_CURSOR_ON       = 5'd8,
    KIND_BLINK_OFF       = 5'd9,
    KIND_BLINK_ON        = 5'd10,
    KIND_SHIFT_LEFT      = 5'd11,
    KIND_SHIFT_RIGHT     = 5'd12,
    KIND_LTR             = 5'd13,
    KIND_RTL             = 5'd14,
    KIND_AUTOSCROLL_ON   = 5'd15,
    KIND_AUTOSCROLL_OFF  = 5'd16,
    KIND_BACKLIGHT_ON    = 5'd17,
    KIND_BACKLIGHT_OFF   = 5'd18
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ARG     = 3'd1,
    ST_BAD_STATE   = 3'd2,
    ST_BAD_ROWS    = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_t;

  // One command transaction
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] char_code;
    logic [5:0] column;
    logic [1:0] row;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] expander_byte;
    logic       has_byte;
    logic [2:0] status;
    logic       last;
  } result_t;

  // One queued job: a bus byte (or a lone high nibble), or a status-only result
  typedef struct packed {
    logic [7:0] byte_val;
    logic       rs;
    logic       bl;
    logic       half;
    logic       has_byte;
    logic       last;
    status_t    status;
  } job_t;

  // Queue status seen by the front end and the serializer
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

### design/lcs_job_q.sv
module lcs_job_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcs_pkg::job_t   push_job,
  input  logic            pop,
  output lcs_pkg::job_t   head_job,
  output lcs_pkg::q_stat_t stat
);

  localparam int PW = lcs_pkg::JOB_Q_PTR_W;

  lcs_pkg::job_t          mem_r [lcs_pkg::JOB_Q_DEPTH];
  logic [PW-1:0]          wr_ptr_r;
  logic [PW-1:0]          rd_ptr_r;
  logic [PW:0]            count_r;

  assign stat.full  = (count_r == (PW+1)'(lcs_pkg::JOB_Q_DEPTH));
  assign stat.valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

endmodule

### design/lcs_front.sv
module lcs_front #(
  parameter int MAX_COLUMNS = lcs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_push,
  input  lcs_pkg::cmd_t                   in_cmd,
  output logic                            in_full,
  input  lcs_pkg::q_stat_t                q_stat,
  output logic                            q_push,
  output lcs_pkg::job_t                   q_job
);

  localparam logic [3:0] INIT_LAST_STEP = 4'd8;

  // Configuration registers
  logic [5:0] columns_r;
  logic [2:0] rows_r;
  logic [4:0] fbits_r;
  logic [2:0] idc_r;
  logic [1:0] iem_r;

  // Tracked display state
  logic [5:0] cur_col_r, cur_col_nxt;
  logic [1:0] cur_line_r, cur_line_nxt;
  logic [2:0] disp_r, disp_nxt;
  logic [1:0] entry_r, entry_nxt;
  logic       bl_r, bl_nxt;
  logic       init_done_r;

  // Init sequencer
  logic       init_busy_r;
  logic [3:0] init_step_r;

  logic          accept;
  logic          init_start;
  lcs_pkg::job_t cmd_job;
  lcs_pkg::job_t init_job;

  // Cursor helpers
  logic          adv_wrap;
  logic [5:0]    adv_col;
  logic [1:0]    adv_line;
  lcs_pkg::status_t adv_st;
  logic [5:0]    ret_col;
  logic [1:0]    ret_line;
  logic [5:0]    pc_col;
  logic [1:0]    pc_line;
  logic          pc_bad;
  logic [7:0]    pc_byte;
  logic          rows_four;
  logic          rows_two;

  function automatic logic [6:0] line_offset(input logic [1:0] l);
    logic [6:0] off;
    case (l)
      2'd0:    off = 7'h00;
      2'd1:    off = 7'h40;
      2'd2:    off = 7'h14;
      default: off = 7'h54;
    endcase
    return off;
  endfunction

  assign in_full = init_busy_r || q_stat.full;
  assign accept  = in_push && !in_full;

  assign rows_four = (rows_r == 3'd4);
  assign rows_two  = (rows_r == 3'd2);

  // Move right one place, wrapping to the next line by row count
  always_comb begin
    adv_wrap = (({1'b0, cur_col_r} + 7'd1) >= {1'b0, columns_r});
    adv_col  = adv_wrap ? 6'd0 : cur_col_r + 6'd1;
    adv_line = cur_line_r;
    adv_st   = lcs_pkg::ST_OK;
    if (adv_wrap) begin
      if (rows_four) begin
        case (cur_line_r)
          2'd0:    adv_line = 2'd2;
          2'd1:    adv_line = 2'd3;
          2'd2:    adv_line = 2'd1;
          default: adv_line = 2'd0;
        endcase
      end else if (rows_two) begin
        adv_line = {1'b0, ~cur_line_r[0]};
      end else begin
        adv_st = lcs_pkg::ST_BAD_ROWS;
      end
    end
  end

  // Move left one place, wrapping to the previous line by row count
  always_comb begin
    ret_line = cur_line_r;
    if (cur_col_r != 6'd0) begin
      ret_col = cur_col_r - 6'd1;
    end else begin
      ret_col = columns_r - 6'd1;
      if (rows_four) begin
        case (cur_line_r)
          2'd0:    ret_line = 2'd3;
          2'd1:    ret_line = 2'd2;
          2'd2:    ret_line = 2'd0;
          default: ret_line = 2'd1;
        endcase
      end else if (rows_two) begin
        ret_line = {1'b0, ~cur_line_r[0]};
      end
    end
  end

  // Set-address byte for an explicit or current cursor position
  always_comb begin
    if (in_cmd.kind == lcs_pkg::KIND_SET_CURSOR) begin
      pc_col  = in_cmd.column;
      pc_line = in_cmd.row;
    end else begin
      pc_col  = cur_col_r;
      pc_line = cur_line_r;
    end
    pc_bad  = (pc_col >= columns_r) || ({1'b0, pc_line} >= rows_r);
    pc_byte = 8'h80 | ({2'b00, pc_col} + {1'b0, line_offset(pc_line)});
  end

  // Decode the command into one job and the next tracked state
  always_comb begin
    cmd_job          = '0;
    cmd_job.bl       = bl_r;
    cmd_job.has_byte = 1'b1;
    cmd_job.last     = 1'b1;
    cmd_job.status   = lcs_pkg::ST_OK;
    cur_col_nxt      = cur_col_r;
    cur_line_nxt     = cur_line_r;
    disp_nxt         = disp_r;
    entry_nxt        = entry_r;
    bl_nxt           = bl_r;
    init_start       = 1'b0;

    case (in_cmd.kind)
      lcs_pkg::KIND_INIT: begin
        cmd_job.has_byte = 1'b0;
        if (fbits_r[4]) begin
          cmd_job.status = lcs_pkg::ST_BAD_ARG;
        end else if (init_done_r) begin
          cmd_job.status = lcs_pkg::ST_BAD_STATE;
        end else begin
          init_start   = 1'b1;
          disp_nxt     = idc_r | 3'b100;
          entry_nxt    = iem_r | 2'b10;
          cur_col_nxt  = 6'd0;
          cur_line_nxt = 2'd0;
        end
      end
      lcs_pkg::KIND_CHAR: begin
        if (in_cmd.char_code == 8'd0) begin
          cmd_job.has_byte = 1'b0;
          cmd_job.status   = lcs_pkg::ST_BAD_ARG;
        end else begin
          cmd_job.byte_val = in_cmd.char_code;
          cmd_job.rs       = 1'b1;
          if (entry_r[1]) begin
            cur_col_nxt    = adv_col;
            cur_line_nxt   = adv_line;
            cmd_job.status = adv_st;
          end else begin
            cur_col_nxt  = ret_col;
            cur_line_nxt = ret_line;
          end
        end
      end
      lcs_pkg::KIND_HOME: begin
        cmd_job.byte_val = 8'h02;
        cur_col_nxt      = 6'd0;
        cur_line_nxt     = 2'd0;
      end
      lcs_pkg::KIND_SET_CURSOR,
      lcs_pkg::KIND_BACKLIGHT_ON,
      lcs_pkg::KIND_BACKLIGHT_OFF: begin
        if (in_cmd.kind == lcs_pkg::KIND_BACKLIGHT_ON) begin
          bl_nxt = 1'b1;
        end else if (in_cmd.kind == lcs_pkg::KIND_BACKLIGHT_OFF) begin
          bl_nxt = 1'b0;
        end
        cmd_job.bl = bl_nxt;
        if (pc_bad) begin
          cmd_job.has_byte = 1'b0;
          cmd_job.status   = lcs_pkg::ST_BAD_ARG;
        end else begin
          cmd_job.byte_val = pc_byte;
          cur_col_nxt      = pc_col;
          cur_line_nxt     = pc_line;
        end
      end
      lcs_pkg::KIND_CLEAR: begin
        cmd_job.byte_val = 8'h01;
        cur_col_nxt      = 6'd0;
        cur_line_nxt     = 2'd0;
        entry_nxt        = entry_r | 2'b10;
      end
      lcs_pkg::KIND_DISPLAY_OFF: begin
        disp_nxt         = disp_r & 3'b011;
        cmd_job.byte_val = {5'b00001, disp_nxt};
      end
      lcs_pkg::KIND_DISPLAY_ON: begin
        disp_nxt         = disp_r | 3'b100;
        cmd_job.byte_val = {5'b00001, disp_nxt};
      end
      lcs_pkg::KIND_CURSOR_OFF: begin
        disp_nxt         = disp_r & 3'b101;
        cmd_job.byte_val = {5'b00001, disp_nxt};
      end
      lcs_pkg::KIND_CURSOR_ON: begin
        disp_nxt         = disp_r | 3'b010;
        cmd_job.byte_val = {5'b00001, disp_nxt};
      end
      lcs_pkg::KIND_BLINK_OFF: begin
        disp_nxt         = disp_r & 3'b110;
        cmd_job.byte_val = {5'b00001, disp_nxt};
      end
      lcs_pkg::KIND_BLINK_ON: begin
        disp_nxt         = disp_r | 3'b001;
        cmd_job.byte_val = {5'b00001, disp_nxt};
      end
      lcs_pkg::KIND_SHIFT_LEFT: begin
        cmd_job.byte_val = 8'h18;
        cur_col_nxt      = ret_col;
        cur_line_nxt     = ret_line;
      end
      lcs_pkg::KIND_SHIFT_RIGHT: begin
        cmd_job.byte_val = 8'h1C;
        cur_col_nxt      = adv_col;
        cur_line_nxt     = adv_line;
        cmd_job.status   = adv_st;
      end
      lcs_pkg::KIND_LTR: begin
        entry_nxt        = entry_r | 2'b10;
        cmd_job.byte_val = {6'b000001, entry_nxt};
      end
      lcs_pkg::KIND_RTL: begin
        entry_nxt        = entry_r & 2'b01;
        cmd_job.byte_val = {6'b000001, entry_nxt};
      end
      lcs_pkg::KIND_AUTOSCROLL_ON: begin
        cmd_job.has_byte = 1'b0;
        cmd_job.status   = lcs_pkg::ST_UNSUPPORTED;
      end
      lcs_pkg::KIND_AUTOSCROLL_OFF: begin
        entry_nxt        = entry_r & 2'b10;
        cmd_job.byte_val = {6'b000001, entry_nxt};
      end
      default: begin
        cmd_job.has_byte = 1'b0;
        cmd_job.status   = lcs_pkg::ST_BAD_ARG;
      end
    endcase
  end

  // Init sequence: four lone nibbles, then five full bytes
  always_comb begin
    init_job          = '0;
    init_job.bl       = bl_r;
    init_job.has_byte = 1'b1;
    init_job.status   = lcs_pkg::ST_OK;
    case (init_step_r)
      4'd0, 4'd1, 4'd2: begin
        init_job.byte_val = 8'h30;
        init_job.half     = 1'b1;
      end
      4'd3: begin
        init_job.byte_val = 8'h20;
        init_job.half     = 1'b1;
      end
      4'd4:    init_job.byte_val = {3'b001, fbits_r};
      4'd5:    init_job.byte_val = {5'b00001, disp_r};
      4'd6:    init_job.byte_val = 8'h01;
      4'd7:    init_job.byte_val = {6'b000001, entry_r};
      default: init_job.byte_val = 8'h02;
    endcase
    init_job.last = (init_step_r == INIT_LAST_STEP);
  end

  assign q_push = init_busy_r ? !q_stat.full : (accept && !init_start);
  assign q_job  = init_busy_r ? init_job : cmd_job;

  // Hold configuration; saturate columns at the supported maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 6'd16;
      rows_r    <= 3'd2;
      fbits_r   <= 5'd8;
      idc_r     <= 3'd0;
      iem_r     <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        lcs_pkg::CFG_COLUMNS: begin
          if ({1'b0, cfg_wdata} > 7'(MAX_COLUMNS)) begin
            columns_r <= 6'(MAX_COLUMNS);
          end else begin
            columns_r <= cfg_wdata;
          end
        end
        lcs_pkg::CFG_ROWS:         rows_r  <= cfg_wdata[2:0];
        lcs_pkg::CFG_FUNCTION:     fbits_r <= cfg_wdata[4:0];
        lcs_pkg::CFG_INIT_DISPLAY: idc_r   <= cfg_wdata[2:0];
        lcs_pkg::CFG_INIT_ENTRY:   iem_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Update tracked state on each accepted transaction; step the init sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= 6'd0;
      cur_line_r  <= 2'd0;
      disp_r      <= 3'd0;
      entry_r     <= 2'd2;
      bl_r        <= 1'b1;
      init_done_r <= 1'b0;
      init_busy_r <= 1'b0;
      init_step_r <= 4'd0;
    end else begin
      if (accept) begin
        cur_col_r  <= cur_col_nxt;
        cur_line_r <= cur_line_nxt;
        disp_r     <= disp_nxt;
        entry_r    <= entry_nxt;
        bl_r       <= bl_nxt;
        if (init_start) begin
          init_done_r <= 1'b1;
          init_busy_r <= 1'b1;
          init_step_r <= 4'd0;
        end
      end else if (init_busy_r && !q_stat.full) begin
        if (init_step_r == INIT_LAST_STEP) begin
          init_busy_r <= 1'b0;
        end
        init_step_r <= init_step_r + 4'd1;
      end
    end
  end

`ifndef SYNTH
  a_busy_after_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy_r |-> init_done_r)
    else $error("init sequence running without init mark");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into a full queue");
`endif

endmodule

### design/lcs_back.sv
module lcs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lcs_pkg::q_stat_t q_stat,
  input  lcs_pkg::job_t    q_job,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output lcs_pkg::result_t out_result
);

  logic [2:0]       phase_r;
  logic [2:0]       final_phase;
  logic             at_final;
  logic             load;
  logic [3:0]       nib;
  logic             en;
  lcs_pkg::result_t res_nxt;
  lcs_pkg::result_t out_r;
  logic             out_valid_r;

  // Last phase of the head job: one status result, three or six expander bytes
  always_comb begin
    if (!q_job.has_byte) begin
      final_phase = 3'd0;
    end else if (q_job.half) begin
      final_phase = 3'd2;
    end else begin
      final_phase = 3'd5;
    end
  end

  assign at_final = (phase_r == final_phase);
  assign load     = q_stat.valid && (!out_valid_r || out_pop);
  assign q_pop    = load && at_final;

  // Build the expander byte for the current phase
  always_comb begin
    nib = (phase_r < 3'd3) ? q_job.byte_val[7:4] : q_job.byte_val[3:0];
    en  = (phase_r == 3'd1) || (phase_r == 3'd4);
    res_nxt = '0;
    if (q_job.has_byte) begin
      res_nxt.expander_byte = {nib, 4'b0000}
                            | (q_job.bl ? lcs_pkg::BIT_BL : 8'h00)
                            | (en ? lcs_pkg::BIT_EN : 8'h00)
                            | (q_job.rs ? lcs_pkg::BIT_RS : 8'h00);
      res_nxt.has_byte = 1'b1;
    end
    res_nxt.last   = q_job.last && at_final;
    res_nxt.status = res_nxt.last ? q_job.status : lcs_pkg::ST_OK;
  end

  assign out_empty  = !out_valid_r;
  assign out_result = out_r;

  // Hold the result register; refill it as it drains
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res_nxt;
    end
  end

  // Advance the phase counter and output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= at_final ? 3'd0 : phase_r + 3'd1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 3'd0) |-> q_stat.valid)
    else $error("job left the queue before its bytes were sent");

  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != lcs_pkg::ST_OK)) |-> out_r.last)
    else $error("nonzero status on a result that is not last");
`endif

endmodule

### design/char_lcd_command_serializer_core.sv
// Character-LCD command serializer for a 4-bit bus behind an 8-bit port
// expander. Commands enter through a queue-style port (in_push/in_full) and
// expander bytes leave through another (out_empty/out_pop), one result per
// cycle while out_pop drains them. Each bus byte goes out as six expander
// bytes (high nibble then low, each as data, data with enable, data without
// enable); a normal command therefore gives six expander bytes, init gives 42,
// and a rejected command gives one status-only result. The output rate is set
// by the serializer, which emits one expander byte per cycle while results are
// popped; a four-entry job queue lets new commands be decoded while earlier
// bytes are still going out, and in_full is high whenever that queue is full.
// While the init sequence is being queued (nine jobs, one per cycle while the
// job queue is not full), in_full stays high. Configuration is written through
// cfg_we/cfg_index/cfg_wdata by the user while idle; the block does not enforce it.
module char_lcd_command_serializer_core #(
  parameter int MAX_COLUMNS = lcs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  lcs_pkg::cmd_t                   in_cmd,
  output logic                            out_empty,
  input  logic                            out_pop,
  output lcs_pkg::result_t                out_result,
  input  logic                            cfg_we,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  lcs_pkg::q_stat_t q_stat;
  lcs_pkg::job_t    push_job;
  lcs_pkg::job_t    head_job;
  logic             q_push;
  logic             q_pop;

  lcs_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_cmd    (in_cmd),
    .in_full   (in_full),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  lcs_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  lcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

endmodule
